// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker of the polygon fan vertex generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property that is switched off while reset is held.
`define PFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A clocked implication that is switched off while reset is held.
`define PFV_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== sv/pfv_pkg.sv =====
// Shared constants and types of the polygon fan vertex generator.
package pfv_pkg;

  localparam int unsigned IdxW       = 11;
  localparam int unsigned CornerW    = 11;
  localparam int unsigned MinCorners = 3;
  localparam int unsigned MaxCorners = 1024;
  localparam int unsigned PhaseBits  = 16;
  localparam int unsigned QuoW       = PhaseBits + 1;
  localparam int unsigned RemW       = CornerW + 1;
  localparam int unsigned AngW       = 30;
  localparam int unsigned AccW       = 32;
  localparam int unsigned PosW       = 16;
  localparam int unsigned ColW       = 8;

  localparam logic [33:0] PiQ32 = 34'h3_243F_6A88;

  typedef enum logic [1:0] {
    QuadFirst,
    QuadSecond,
    QuadThird,
    QuadFourth
  } quad_e;

  typedef struct packed {
    logic            centre;
    quad_e           quad;
    logic            swap;
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
  } side_t;

  typedef struct packed {
    logic [AngW-1:0] t;
    logic [AngW-1:0] c;
    logic [AngW-1:0] a2;
    logic [AccW-1:0] sacc;
    logic [AccW-1:0] cacc;
  } trig_t;

endpackage

// ===== sv/polygon_fan_vertex_generator.sv =====
// Top level of the polygon fan vertex generator: position and hue colour per fan vertex.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    vertex_index_i
//   result    out        out_valid_o / out_stall_i  pos_x_o pos_y_o red_o green_o blue_o
//   config    in         cfg_we_i                   cfg_wdata_i
//
// A new word is taken every cycle unless in_stall_o is high; each word passes in order through an
// input register, 28 restoring division steps, three angle stages, four three-stage Taylor
// terms and the output register.
// Every stage holds a valid bit, so empty stages keep filling while the output is stalled.
// Reset clears all valid bits and sets the corner count to three.
module polygon_fan_vertex_generator import pfv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CornerW-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [IdxW-1:0]        vertex_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o,
  output logic [ColW-1:0]        red_o,
  output logic [ColW-1:0]        green_o,
  output logic [ColW-1:0]        blue_o
);

  localparam int unsigned One     = 1 << PhaseBits;
  localparam int unsigned Quarter = One >> 2;
  localparam int unsigned Eighth  = One >> 3;
  localparam int unsigned SW      = PhaseBits - 2;
  localparam int unsigned MW      = PhaseBits + 3;

  typedef enum logic [2:0] {
    SecRy,
    SecYg,
    SecGc,
    SecCb,
    SecBm,
    SecMr
  } sector_e;

  logic [CornerW-1:0] corner_q, corner_d;

  logic                 ph_valid, ph_ready, ph_centre, ph_ready_in;
  logic [PhaseBits-1:0] ph_phase;

  logic en_f, en_a, en_b, en_o;
  logic fv_q, av_q, bv_q, ov_q;
  side_t fside_q, aside_q, bside_q, fside_d;
  logic [SW-1:0]   fs_q, fs_d, fr;
  logic [SW:0]     fsw;
  logic [AngW-1:0] a_q, a2;
  logic [MW+AngW-2:0] aprod;
  logic [2*AngW-1:0]  sqprod;
  trig_t btrig_q, btrig_d;

  logic [MW-1:0]        cm, cm_dec;
  logic [2:0]           sec;
  logic [PhaseBits:0]   cf, cx;
  logic [PhaseBits+8:0] cv_prod;
  logic [ColW-1:0]      cv;

  logic [4:0] tv, tr;
  side_t      ts[5];
  trig_t      tt[5];

  logic [AccW-1:0] hs_sum, hc_sum;
  logic [PosW-1:0] hs, hc, u, w, px_d, py_d;
  logic signed [PosW-1:0] pos_x_q, pos_y_q;
  logic [ColW-1:0] red_q, green_q, blue_q;

  // Configuration register holds the corner count already clamped to its legal range.
  always_comb begin
    if (cfg_wdata_i < CornerW'(MinCorners)) begin
      corner_d = CornerW'(MinCorners);
    end else if (cfg_wdata_i > CornerW'(MaxCorners)) begin
      corner_d = CornerW'(MaxCorners);
    end else begin
      corner_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= CornerW'(MinCorners);
    end else if (cfg_we_i) begin
      corner_q <= corner_d;
    end
  end

  pfv_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .corners_i   (corner_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (ph_ready_in),
    .idx_i       (vertex_index_i),
    .out_valid_o (ph_valid),
    .out_ready_i (ph_ready),
    .phase_o     (ph_phase),
    .centre_o    (ph_centre)
  );

  assign in_stall_o = !ph_ready_in;

  assign en_o = !ov_q || !out_stall_i;
  assign tr[4] = en_o;
  assign en_b = !bv_q || tr[0];
  assign en_a = !av_q || en_b;
  assign en_f = !fv_q || en_a;
  assign ph_ready = en_f;

  // Fold the phase into one octant and work out the hue colour.
  assign fr  = ph_phase[SW-1:0];
  assign fsw = (SW+1)'(Quarter) - {1'b0, fr};
  assign fs_d = (fr > SW'(Eighth)) ? fsw[SW-1:0] : fr;

  assign cm      = MW'(ph_phase) * MW'(6);
  assign cm_dec  = cm - 1'b1;
  assign sec     = (cm <= MW'(One)) ? '0 : cm_dec[MW-1:PhaseBits];
  assign cf      = cm[PhaseBits:0];
  assign cx      = cf[PhaseBits] ? (PhaseBits+1)'(~cf + 1'b1) : cf;
  assign cv_prod = (PhaseBits+9)'(cx) * (PhaseBits+9)'(255);
  assign cv      = cv_prod[PhaseBits+7:PhaseBits];

  always_comb begin
    fside_d.centre = ph_centre;
    fside_d.quad   = quad_e'(ph_phase[PhaseBits-1:PhaseBits-2]);
    fside_d.swap   = fr > SW'(Eighth);
    unique case (sector_e'(sec))
      SecRy: begin
        fside_d.red = '1; fside_d.green = cv; fside_d.blue = '0;
      end
      SecYg: begin
        fside_d.red = cv; fside_d.green = '1; fside_d.blue = '0;
      end
      SecGc: begin
        fside_d.red = '0; fside_d.green = '1; fside_d.blue = cv;
      end
      SecCb: begin
        fside_d.red = '0; fside_d.green = cv; fside_d.blue = '1;
      end
      SecBm: begin
        fside_d.red = cv; fside_d.green = '0; fside_d.blue = '1;
      end
      default: begin
        fside_d.red = '1; fside_d.green = '0; fside_d.blue = cv;
      end
    endcase
    if (ph_centre) begin
      fside_d.red   = '1;
      fside_d.green = '1;
      fside_d.blue  = '1;
    end
  end

  assign aprod  = (MW+AngW-1)'(fs_q) * (MW+AngW-1)'(PiQ32);
  assign sqprod = (2*AngW)'(a_q) * (2*AngW)'(a_q);
  assign a2     = sqprod[2*AngW-1:AngW];

  always_comb begin
    btrig_d.t    = a_q;
    btrig_d.c    = a2 >> 1;
    btrig_d.a2   = a2;
    btrig_d.sacc = AccW'(a_q);
    btrig_d.cacc = AccW'(1 << AngW) - AccW'(a2 >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
      av_q <= 1'b0;
      bv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en_f) begin
        fv_q <= ph_valid;
      end
      if (en_a) begin
        av_q <= fv_q;
      end
      if (en_b) begin
        bv_q <= av_q;
      end
      if (en_o) begin
        ov_q <= tv[4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f) begin
      fside_q <= fside_d;
      fs_q    <= fs_d;
    end
    if (en_a) begin
      aside_q <= fside_q;
      a_q     <= aprod[AngW+PhaseBits:PhaseBits+1];
    end
    if (en_b) begin
      bside_q <= aside_q;
      btrig_q <= btrig_d;
    end
  end

  assign tv[0] = bv_q;
  assign ts[0] = bside_q;
  assign tt[0] = btrig_q;

  pfv_term #(.DivS(6), .DivC(12), .SubS(1'b1), .HasC(1'b1)) u_term3 (
    .clk_i, .rst_ni,
    .in_valid_i (tv[0]), .in_ready_o (tr[0]), .in_side_i (ts[0]), .in_trig_i (tt[0]),
    .out_valid_o(tv[1]), .out_ready_i(tr[1]), .out_side_o(ts[1]), .out_trig_o(tt[1])
  );

  pfv_term #(.DivS(20), .DivC(30), .SubS(1'b0), .HasC(1'b1)) u_term5 (
    .clk_i, .rst_ni,
    .in_valid_i (tv[1]), .in_ready_o (tr[1]), .in_side_i (ts[1]), .in_trig_i (tt[1]),
    .out_valid_o(tv[2]), .out_ready_i(tr[2]), .out_side_o(ts[2]), .out_trig_o(tt[2])
  );

  pfv_term #(.DivS(42), .DivC(56), .SubS(1'b1), .HasC(1'b1)) u_term7 (
    .clk_i, .rst_ni,
    .in_valid_i (tv[2]), .in_ready_o (tr[2]), .in_side_i (ts[2]), .in_trig_i (tt[2]),
    .out_valid_o(tv[3]), .out_ready_i(tr[3]), .out_side_o(ts[3]), .out_trig_o(tt[3])
  );

  pfv_term #(.DivS(72), .DivC(1), .SubS(1'b0), .HasC(1'b0)) u_term9 (
    .clk_i, .rst_ni,
    .in_valid_i (tv[3]), .in_ready_o (tr[3]), .in_side_i (ts[3]), .in_trig_i (tt[3]),
    .out_valid_o(tv[4]), .out_ready_i(tr[4]), .out_side_o(ts[4]), .out_trig_o(tt[4])
  );

  // Round the Q30 values to half scale in Q1.15 and unfold the octant and quadrant.
  assign hs_sum = tt[4].sacc + AccW'(32'h8000);
  assign hc_sum = tt[4].cacc + AccW'(32'h8000);
  assign hs     = hs_sum[AccW-1:AccW-PosW];
  assign hc     = hc_sum[AccW-1:AccW-PosW];
  assign u      = ts[4].swap ? hs : hc;
  assign w      = ts[4].swap ? hc : hs;

  always_comb begin
    unique case (ts[4].quad)
      QuadFirst: begin
        px_d = u;  py_d = w;
      end
      QuadSecond: begin
        px_d = -w; py_d = u;
      end
      QuadThird: begin
        px_d = -u; py_d = -w;
      end
      QuadFourth: begin
        px_d = w;  py_d = -u;
      end
    endcase
    if (ts[4].centre) begin
      px_d = '0;
      py_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      pos_x_q <= px_d;
      pos_y_q <= py_d;
      red_q   <= ts[4].red;
      green_q <= ts[4].green;
      blue_q  <= ts[4].blue;
    end
  end

  assign out_valid_o = ov_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

// ===== sv/pfv_phase.sv =====
// Pipelined corner modulo and phase division, one restoring step per stage.
module pfv_phase import pfv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CornerW-1:0]   corners_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IdxW-1:0]      idx_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PhaseBits-1:0] phase_o,
  output logic                 centre_o
);

  localparam int unsigned ModSteps  = IdxW;
  localparam int unsigned NumStages = 1 + ModSteps + QuoW;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_in;
  logic [NumStages:0]   en;
  logic [NumStages-1:0] centre_q;
  logic [NumStages-1:0] centre_in;

  logic [IdxW-1:0]    num_q   [ModSteps];
  logic [CornerW-1:0] mrem_q  [ModSteps];
  logic [CornerW-1:0] mrem_d  [ModSteps];
  logic [CornerW:0]   mtrial  [ModSteps];

  logic [RemW-1:0]    frem_q  [QuoW];
  logic [RemW-1:0]    frem_d  [QuoW];
  logic [RemW:0]      ftrial  [QuoW];
  logic [QuoW-1:0]    quo_q   [QuoW];
  logic [QuoW-1:0]    quo_d   [QuoW];
  logic [QuoW-1:0]    quo_prev[QuoW];

  logic [QuoW-1:0] cbits;
  logic [RemW:0]   div2;
  logic [CornerW:0] div1;

  assign cbits = QuoW'(corners_i);
  assign div2  = {1'b0, corners_i, 1'b0};
  assign div1  = {1'b0, corners_i};

  assign en[NumStages] = out_ready_i;
  for (genvar j = 0; j < NumStages; j++) begin : g_en
    assign en[j] = !valid_q[j] || en[j+1];
  end

  assign valid_in  = {valid_q[NumStages-2:0], in_valid_i};
  assign centre_in = {centre_q[NumStages-2:0], idx_i == '0};

  for (genvar s = 0; s < ModSteps; s++) begin : g_mstep
    if (s == 0) begin : g_first
      assign mtrial[s] = {{CornerW{1'b0}}, num_q[s][ModSteps-1-s]};
    end else begin : g_next
      assign mtrial[s] = {mrem_q[s-1], num_q[s][ModSteps-1-s]};
    end
    assign mrem_d[s] = (mtrial[s] >= div1) ? CornerW'(mtrial[s] - div1)
                                           : CornerW'(mtrial[s]);
  end

  for (genvar f = 0; f < QuoW; f++) begin : g_fstep
    if (f == 0) begin : g_first
      assign ftrial[f]   = {1'b0, mrem_q[ModSteps-1], cbits[QuoW-1-f]};
      assign quo_prev[f] = '0;
    end else begin : g_next
      assign ftrial[f]   = {frem_q[f-1], cbits[QuoW-1-f]};
      assign quo_prev[f] = quo_q[f-1];
    end
    assign frem_d[f] = (ftrial[f] >= div2) ? RemW'(ftrial[f] - div2) : RemW'(ftrial[f]);
    assign quo_d[f]  = {quo_prev[f][QuoW-2:0], ftrial[f] >= div2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int j = 0; j < NumStages; j++) begin
        if (en[j]) begin
          valid_q[j] <= valid_in[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NumStages; j++) begin
      if (en[j]) begin
        centre_q[j] <= centre_in[j];
      end
    end
    if (en[0]) begin
      num_q[0] <= IdxW'(idx_i - 1'b1);
    end
    for (int s = 1; s < ModSteps; s++) begin
      if (en[s]) begin
        num_q[s] <= num_q[s-1];
      end
    end
    for (int s = 0; s < ModSteps; s++) begin
      if (en[s+1]) begin
        mrem_q[s] <= mrem_d[s];
      end
    end
    for (int f = 0; f < QuoW; f++) begin
      if (en[ModSteps+1+f]) begin
        frem_q[f] <= frem_d[f];
        quo_q[f]  <= quo_d[f];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign phase_o     = quo_q[QuoW-1][PhaseBits-1:0];
  assign centre_o    = centre_q[NumStages-1];

endmodule

// ===== sv/pfv_term.sv =====
// One Taylor series step for sine and, when HasC is set, cosine, three pipeline stages.
module pfv_term import pfv_pkg::*; #(
  parameter int unsigned DivS = 6,
  parameter int unsigned DivC = 12,
  parameter bit          SubS = 1'b1,
  parameter bit          HasC = 1'b1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  side_t in_side_i,
  input  trig_t in_trig_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output side_t out_side_o,
  output trig_t out_trig_o
);

  localparam logic [AngW:0] RecipS = (AngW+1)'((64'd1 << AngW) / DivS);
  localparam logic [AngW:0] RecipC = (AngW+1)'((64'd1 << AngW) / DivC);

  logic [2:0] valid_q;
  logic [2:0] valid_in;
  logic [3:0] en;

  side_t side1_q, side2_q, side3_q;
  trig_t tr1_q, tr2_q, tr3_q, trig_d;

  logic [AngW-1:0] ps1_q, pc1_q, ps2_q, pc2_q, qs2_q, qc2_q;
  logic [2*AngW-1:0] ps_prod, pc_prod;
  logic [2*AngW:0]   qs_prod, qc_prod;
  logic [AngW-1:0] rs, rc, qs, qc;

  assign en[3] = out_ready_i;
  for (genvar j = 0; j < 3; j++) begin : g_en
    assign en[j] = !valid_q[j] || en[j+1];
  end
  assign valid_in = {valid_q[1:0], in_valid_i};

  assign ps_prod = (2*AngW)'(in_trig_i.t) * (2*AngW)'(in_trig_i.a2);
  assign pc_prod = (2*AngW)'(in_trig_i.c) * (2*AngW)'(in_trig_i.a2);

  // The reciprocal estimate is at most one below the true quotient.
  assign qs_prod = (2*AngW+1)'(ps1_q) * (2*AngW+1)'(RecipS);
  assign qc_prod = (2*AngW+1)'(pc1_q) * (2*AngW+1)'(RecipC);

  assign rs = ps2_q - AngW'(qs2_q * DivS);
  assign rc = pc2_q - AngW'(qc2_q * DivC);
  assign qs = qs2_q + AngW'(rs >= AngW'(DivS));
  assign qc = qc2_q + AngW'(rc >= AngW'(DivC));

  always_comb begin
    trig_d   = tr2_q;
    trig_d.t = qs;
    if (SubS) begin
      trig_d.sacc = tr2_q.sacc - AccW'(qs);
    end else begin
      trig_d.sacc = tr2_q.sacc + AccW'(qs);
    end
    if (HasC) begin
      trig_d.c = qc;
      if (SubS) begin
        trig_d.cacc = tr2_q.cacc + AccW'(qc);
      end else begin
        trig_d.cacc = tr2_q.cacc - AccW'(qc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int j = 0; j < 3; j++) begin
        if (en[j]) begin
          valid_q[j] <= valid_in[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side1_q <= in_side_i;
      tr1_q   <= in_trig_i;
      ps1_q   <= ps_prod[2*AngW-1:AngW];
      pc1_q   <= pc_prod[2*AngW-1:AngW];
    end
    if (en[1]) begin
      side2_q <= side1_q;
      tr2_q   <= tr1_q;
      ps2_q   <= ps1_q;
      pc2_q   <= pc1_q;
      qs2_q   <= qs_prod[2*AngW-1:AngW];
      qc2_q   <= qc_prod[2*AngW-1:AngW];
    end
    if (en[2]) begin
      side3_q <= side2_q;
      tr3_q   <= trig_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[2];
  assign out_side_o  = side3_q;
  assign out_trig_o  = tr3_q;

endmodule

// ===== sv/pfv_checker.sv =====
// Port-level checker of the polygon fan vertex generator and its bind statement.
`include "assert_macros.svh"

module pfv_port_checker import pfv_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [CornerW-1:0]     cfg_wdata_i,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [IdxW-1:0]        vertex_index_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [PosW-1:0] pos_x_o,
  input logic signed [PosW-1:0] pos_y_o,
  input logic [ColW-1:0]        red_o,
  input logic [ColW-1:0]        green_o,
  input logic [ColW-1:0]        blue_o
);

  logic any_full, is_white, at_centre, in_range;

  assign any_full  = red_o == 8'hFF || green_o == 8'hFF || blue_o == 8'hFF;
  assign is_white  = red_o == 8'hFF && green_o == 8'hFF && blue_o == 8'hFF;
  assign at_centre = pos_x_o == 16'sd0 && pos_y_o == 16'sd0;
  assign in_range  = pos_x_o >= -16'sd16384 && pos_x_o <= 16'sd16384 &&
                     pos_y_o >= -16'sd16384 && pos_y_o <= 16'sd16384;

  `PFV_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled word was dropped")

  `PFV_ASSERT_IMPL(a_colour_full, out_valid_o, any_full, "no colour component is saturated")

  `PFV_ASSERT_IMPL(a_white_centre, out_valid_o && is_white, at_centre, "white vertex off centre")

  `PFV_ASSERT_IMPL(a_pos_range, out_valid_o, in_range, "position outside half scale")

endmodule

bind polygon_fan_vertex_generator pfv_port_checker u_pfv_checker (.*);

// ===== tb/pfv_checker.sv =====
// Checker for the polygon fan vertex generator: predicts each vertex word and compares results.
module pfv_checker import pfv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CornerW-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_o,
  input  logic [IdxW-1:0]        vertex_index_i,
  input  logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic signed [PosW-1:0] pos_x_o,
  input  logic signed [PosW-1:0] pos_y_o,
  input  logic [ColW-1:0]        red_o,
  input  logic [ColW-1:0]        green_o,
  input  logic [ColW-1:0]        blue_o,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PosW-1:0] px;
    logic [PosW-1:0] py;
    logic [ColW-1:0] r;
    logic [ColW-1:0] g;
    logic [ColW-1:0] b;
  } vertex_t;

  vertex_t vertex_q[$];
  logic [CornerW-1:0] corners;

  function automatic logic [PosW-1:0] half_pos(logic [63:0] v);
    logic [63:0] t;
    t = (v + 64'h8000) >> 16;
    return t[PosW-1:0];
  endfunction

  function automatic vertex_t vertex_of(logic [IdxW-1:0] idx, logic [CornerW-1:0] cc);
    vertex_t o;
    logic [63:0] c, k, p, one, q, r, s, a, a2, t3, t5, t7, t9, c2, c4, c6, c8, sn, cs;
    logic [63:0] m, sect, f, x, v;
    logic [PosW-1:0] u, w;
    one = 64'd1 << PhaseBits;
    if (idx == 0) begin
      o = '{px: 0, py: 0, r: 8'hFF, g: 8'hFF, b: 8'hFF};
      return o;
    end
    c = cc;
    if (c < MinCorners) c = MinCorners;
    if (c > MaxCorners) c = MaxCorners;
    k = (idx - 1) % c;
    p = ((k << (PhaseBits + 1)) + c) / (2 * c);
    p &= one - 1;
    q = p >> (PhaseBits - 2);
    r = p & ((one >> 2) - 1);
    s = (r <= (one >> 3)) ? r : (one >> 2) - r;
    a = (s * 64'h3243F6A88) >> (PhaseBits + 1);
    a2 = (a * a) >> 30;
    t3 = ((a * a2) >> 30) / 6;
    t5 = ((t3 * a2) >> 30) / 20;
    t7 = ((t5 * a2) >> 30) / 42;
    t9 = ((t7 * a2) >> 30) / 72;
    c2 = a2 / 2;
    c4 = ((c2 * a2) >> 30) / 12;
    c6 = ((c4 * a2) >> 30) / 30;
    c8 = ((c6 * a2) >> 30) / 56;
    sn = a - t3 + t5 - t7 + t9;
    cs = 64'h40000000 - c2 + c4 - c6 + c8;
    if (r <= (one >> 3)) begin
      u = half_pos(cs); w = half_pos(sn);
    end else begin
      u = half_pos(sn); w = half_pos(cs);
    end
    case (quad_e'(q[1:0]))
      QuadFirst:  begin o.px = u;  o.py = w;  end
      QuadSecond: begin o.px = -w; o.py = u;  end
      QuadThird:  begin o.px = -u; o.py = -w; end
      default:    begin o.px = w;  o.py = -u; end
    endcase
    m = 6 * p;
    sect = (m <= one) ? 0 : ((m - 1) >> PhaseBits);
    f = m & ((one << 1) - 1);
    x = (f >= one) ? one - (f - one) : f;
    v = (255 * x) >> PhaseBits;
    case (sect)
      0: begin o.r = 8'hFF; o.g = v[7:0]; o.b = 0; end
      1: begin o.r = v[7:0]; o.g = 8'hFF; o.b = 0; end
      2: begin o.r = 0; o.g = 8'hFF; o.b = v[7:0]; end
      3: begin o.r = 0; o.g = v[7:0]; o.b = 8'hFF; end
      4: begin o.r = v[7:0]; o.g = 0; o.b = 8'hFF; end
      default: begin o.r = 8'hFF; o.g = 0; o.b = v[7:0]; end
    endcase
    return o;
  endfunction

  assign pending = vertex_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    vertex_t got, want;
    if (!rst_ni) begin
      corners <= MinCorners;
      fail_count <= 0;
      vertex_q.delete();
    end else begin
      if (cfg_we_i) corners <= cfg_wdata_i;
      if (in_valid_i && !in_stall_o) vertex_q.push_back(vertex_of(vertex_index_i, corners));
      if (out_valid_o && !out_stall_i) begin
        got = '{px: pos_x_o, py: pos_y_o, r: red_o, g: green_o, b: blue_o};
        if (vertex_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result word %h", got);
        end else begin
          want = vertex_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Mismatch: x %0d/%0d y %0d/%0d rgb %h%h%h/%h%h%h (expected/actual)",
                       $signed(want.px), $signed(got.px), $signed(want.py), $signed(got.py),
                       want.r, want.g, want.b, got.r, got.g, got.b);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench for the polygon fan vertex generator: stimulus and verdict.
module tb_top import pfv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CornerW-1:0] cfg_wdata_i = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [IdxW-1:0] vertex_index_i = 0;
  logic in_stall_o, out_valid_o;
  logic signed [PosW-1:0] pos_x_o, pos_y_o;
  logic [ColW-1:0] red_o, green_o, blue_o;
  int fail_count, pending, cycles;
  bit calm, hold_long;

  polygon_fan_vertex_generator i_dut (.*);
  pfv_checker i_chk (.*);

  initial forever #2 clk_i = ~clk_i;

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver stalls in bursts, or in one long stretch on request.
  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 0;
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        out_stall_i <= 1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 0;
        @(posedge clk_i);
      end else @(posedge clk_i);
    end
  end

  task automatic send_word(logic [IdxW-1:0] idx);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 15);
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1;
    vertex_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_and_set(logic [CornerW-1:0] value);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [IdxW-1:0] pick_index(logic [CornerW-1:0] cc);
    int c;
    c = (cc < MinCorners) ? MinCorners : (cc > MaxCorners) ? MaxCorners : cc;
    if ($urandom_range(0, 9) == 0) return IdxW'($urandom());
    return IdxW'($urandom_range(0, c + 1));
  endfunction

  initial begin
    logic [CornerW-1:0] setting[8];
    setting = '{11'd3, 11'd0, 11'd2047, 11'd1024, 11'd6, 11'd1025, 11'd0, 11'd0};
    calm = 0;
    hold_long = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (setting[j]) if (j > 5) setting[j] = CornerW'($urandom_range(1, 2047));
    // Directed words at the reset corner count.
    send_word(0); send_word(1); send_word(2); send_word(3);
    send_word(4); send_word(5); send_word(11'h7FF); send_word(11'h400); send_word(11'h555);
    drain_and_set(11'd6);
    for (int i = 0; i < 8; i++) send_word(IdxW'(i));
    drain_and_set(11'd1024);
    send_word(1); send_word(257); send_word(513); send_word(769); send_word(1025);
    send_word(11'h7FF); send_word(129);
    // Random phases, each at its own corner count.
    foreach (setting[j]) begin
      drain_and_set(setting[j]);
      if (j == 2) hold_long = 1;
      if (j == 7) calm = 1;
      for (int i = 0; i < 230; i++) send_word(pick_index(setting[j]));
    end
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== polygon_fan_vertex_generator.f =====
+incdir+sv
sv/pfv_pkg.sv
sv/pfv_phase.sv
sv/pfv_term.sv
sv/polygon_fan_vertex_generator.sv
sv/pfv_checker.sv
tb/pfv_checker.sv
tb/tb_top.sv
